/* design/dtcm_pkg.sv */
package dtcm_pkg;

	// Default number of monitored trouble code records
	localparam int NUM_CHANNELS_DEF = 2;

	// Configuration register indexes
	localparam logic CFG_FAIL_LIMIT = 1'b0;
	localparam logic CFG_DEBOUNCE_THR = 1'b1;

	// Configuration reset values
	localparam logic [15:0] FAIL_LIMIT_RESET = 16'd100;
	localparam logic [6:0] DEBOUNCE_THR_RESET = 7'd10;

	// Aging: release of confirmed at 6, clear of failed-since-clear at 2
	localparam logic [2:0] AGING_RELEASE = 3'd6;
	localparam logic [2:0] AGING_CLEAR_SINCE = 3'd2;

	// Status byte bit positions
	localparam int SB_FAILED = 0;
	localparam int SB_FAILED_CYCLE = 1;
	localparam int SB_PENDING = 2;
	localparam int SB_CONFIRMED = 3;
	localparam int SB_NOT_DONE_CLR = 4;
	localparam int SB_FAILED_CLR = 5;
	localparam int SB_NOT_DONE_CYCLE = 6;

	// Latched debounced result
	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_PASS = 2'd1,
		RES_FAIL = 2'd2
	} result_t;

	// Per-channel record
	typedef struct packed {
		logic signed [8:0] count;
		result_t result;
		logic [6:0] status;
		logic in_aging;
		logic [2:0] aging;
		logic saved_fail;
	} chan_state_t;

	// One sample beat as seen by the update logic
	typedef struct packed {
		logic [15:0] sensor_value;
		logic cycle_prev;
		logic cycle_now;
	} sample_t;

endpackage

/* design/dtcm_update.sv */
module dtcm_update (
	input  dtcm_pkg::chan_state_t cur,
	input  dtcm_pkg::sample_t     smp,
	input  logic [15:0]           fail_limit,
	input  logic [6:0]            debounce_threshold,
	output dtcm_pkg::chan_state_t nxt
);

	logic signed [9:0] cnt_old;
	logic signed [9:0] cnt_new;
	logic signed [9:0] thr;
	logic test_fail;
	logic restart;
	logic now_stop;
	logic failed;
	logic passed;
	logic cond;
	dtcm_pkg::result_t res;
	logic signed [9:0] cnt_fin;
	logic [6:0] st;
	logic in_aging;
	logic [2:0] aging;

	// Debounce counter step and result latch
	always_comb begin
		cnt_old = 10'(cur.count);
		thr = $signed({3'b000, debounce_threshold});
		test_fail = (smp.sensor_value >= fail_limit);
		if (!test_fail) begin
			cnt_new = cnt_old - 10'sd1;
		end else if (cnt_old >= 10'sd0) begin
			cnt_new = cnt_old + 10'sd2;
		end else begin
			cnt_new = 10'sd1;
		end
		res = cur.result;
		cnt_fin = cnt_new;
		if (cnt_new >= thr) begin
			res = dtcm_pkg::RES_FAIL;
			cnt_fin = 10'sd0;
		end else if (cnt_new <= -thr) begin
			res = dtcm_pkg::RES_PASS;
			cnt_fin = 10'sd0;
		end
	end

	// Status bits, confirm stage and aging
	always_comb begin
		restart = !smp.cycle_prev && smp.cycle_now;
		now_stop = !smp.cycle_now;
		failed = (res == dtcm_pkg::RES_FAIL);
		passed = (res == dtcm_pkg::RES_PASS);
		st = cur.status;
		in_aging = cur.in_aging;
		aging = cur.aging;

		st[dtcm_pkg::SB_FAILED] = failed;

		if (restart) begin
			st[dtcm_pkg::SB_FAILED_CYCLE] = 1'b0;
		end else if (failed) begin
			st[dtcm_pkg::SB_FAILED_CYCLE] = 1'b1;
		end

		if (failed) begin
			st[dtcm_pkg::SB_PENDING] = 1'b1;
		end else if (now_stop && !st[dtcm_pkg::SB_FAILED_CYCLE]) begin
			st[dtcm_pkg::SB_PENDING] = 1'b0;
		end

		// confirmation needs a fail in this and the last stop-stop cycle
		cond = st[dtcm_pkg::SB_FAILED_CYCLE] && cur.saved_fail;
		if (!cur.in_aging) begin
			if (cond) begin
				st[dtcm_pkg::SB_CONFIRMED] = 1'b1;
				aging = 3'd0;
				in_aging = 1'b1;
			end else begin
				st[dtcm_pkg::SB_CONFIRMED] = 1'b0;
			end
		end else begin
			if (cur.aging == dtcm_pkg::AGING_RELEASE) begin
				st[dtcm_pkg::SB_CONFIRMED] = 1'b0;
				in_aging = 1'b0;
				aging = 3'd0;
			end else if (failed) begin
				aging = 3'd0;
			end else if (!cond && now_stop) begin
				aging = cur.aging + 3'd1;
			end
		end

		if (passed || failed) begin
			st[dtcm_pkg::SB_NOT_DONE_CLR] = 1'b0;
		end

		if (aging == dtcm_pkg::AGING_CLEAR_SINCE) begin
			st[dtcm_pkg::SB_FAILED_CLR] = 1'b0;
		end else if (failed) begin
			st[dtcm_pkg::SB_FAILED_CLR] = 1'b1;
		end

		if (restart) begin
			st[dtcm_pkg::SB_NOT_DONE_CYCLE] = 1'b1;
		end else if (passed || failed) begin
			st[dtcm_pkg::SB_NOT_DONE_CYCLE] = 1'b0;
		end
	end

	// Next record; snapshot of failed-this-cycle on a stop-stop cycle
	always_comb begin
		nxt.count = cnt_fin[8:0];
		nxt.result = res;
		nxt.status = st;
		nxt.in_aging = in_aging;
		nxt.aging = aging;
		nxt.saved_fail = cur.saved_fail;
		if (!smp.cycle_prev && now_stop) begin
			nxt.saved_fail = st[dtcm_pkg::SB_FAILED_CYCLE];
		end
	end

endmodule

/* design/dtc_status_monitor_top.sv */
// A beat accepted into the input register is updated combinationally and lands
// in the result register, which drives the outputs, once the result stage moves.
// Throughput: one beat per cycle unless the result side stalls, back-to-back on
// the same channel, since each record is read, updated and written back as it moves.
// Reset (arst_n low, asynchronous): all channel records clear to zero, both
// stages empty, fail_limit returns to 100 and debounce_threshold to 10.
module dtc_status_monitor_top #(
	parameter int NUM_CHANNELS = dtcm_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// sample channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        channel,
	input  logic [15:0] sensor_value,
	input  logic        cycle_prev,
	input  logic        cycle_now,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        channel_out,
	output logic [6:0]  status_byte,
	output logic [1:0]  test_result,
	output logic [2:0]  aging_count
);

	localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [15:0] fail_limit_q;
	logic [6:0] thr_q;

	logic valid_s1;
	logic channel_s1;
	dtcm_pkg::sample_t smp_s1;

	logic valid_s2;
	logic channel_s2;
	logic [6:0] status_s2;
	logic [1:0] result_s2;
	logic [2:0] aging_s2;

	dtcm_pkg::chan_state_t rec_q [NUM_CHANNELS];
	dtcm_pkg::chan_state_t cur;
	dtcm_pkg::chan_state_t nxt;

	logic advance;
	logic in_range;
	logic [IdxW-1:0] ch_idx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q <= dtcm_pkg::FAIL_LIMIT_RESET;
			thr_q <= dtcm_pkg::DEBOUNCE_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dtcm_pkg::CFG_FAIL_LIMIT:   fail_limit_q <= cfg_data;
				dtcm_pkg::CFG_DEBOUNCE_THR: thr_q <= cfg_data[6:0];
				default:                    fail_limit_q <= fail_limit_q;
			endcase
		end
	end

	// Handshake: result stage moves when empty or taken
	assign advance = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			channel_s1 <= channel;
			smp_s1.sensor_value <= sensor_value;
			smp_s1.cycle_prev <= cycle_prev;
			smp_s1.cycle_now <= cycle_now;
		end
	end

	// Record select for the beat in the input stage
	assign ch_idx = IdxW'(channel_s1);
	assign in_range = (int'(channel_s1) < NUM_CHANNELS);

	always_comb begin
		cur = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (ch_idx == IdxW'(i)) begin
				cur = rec_q[i];
			end
		end
	end

	dtcm_update u_update (
		.cur                (cur),
		.smp                (smp_s1),
		.fail_limit         (fail_limit_q),
		.debounce_threshold (thr_q),
		.nxt                (nxt)
	);

	// Channel records, written back as the beat moves to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				rec_q[i] <= '0;
			end
		end else if (advance && valid_s1 && in_range) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ch_idx == IdxW'(i)) begin
					rec_q[i] <= nxt;
				end
			end
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			channel_s2 <= channel_s1;
			if (in_range) begin
				status_s2 <= nxt.status;
				result_s2 <= nxt.result;
				aging_s2 <= nxt.aging;
			end else begin
				status_s2 <= '0;
				result_s2 <= dtcm_pkg::RES_NONE;
				aging_s2 <= '0;
			end
		end
	end

	assign out_valid = valid_s2;
	assign channel_out = channel_s2;
	assign status_byte = status_s2;
	assign test_result = result_s2;
	assign aging_count = aging_s2;

`ifndef SYNTH
	// input side only backs up when both stages hold a beat
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free stage");

	// a stalled result keeps the input stage beat in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> (valid_s1 && $stable(channel_s1)))
		else $error("input stage beat lost under stall");

	// latched result is never the unused code
	a_result_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2 != 2'b11))
		else $error("invalid latched result code");

	// aging count never passes the release value
	a_aging_max: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (aging_s2 <= dtcm_pkg::AGING_RELEASE))
		else $error("aging count beyond release");
`endif

endmodule

/* test/tb_dtc_status_monitor_top.sv */
`timescale 1ns / 1ps

module tb_dtc_status_monitor_top;

	// Expected report for one sample beat
	typedef struct {
		bit                  channel;
		logic [6:0]          status;
		dtcm_pkg::result_t   result;
		logic [2:0]          aging;
	} status_beat_t;

	// Per-channel DTC status predictor plus result scoreboard
	class dtc_scoreboard;
		logic [15:0] fail_limit;
		logic [6:0] threshold;
		logic signed [8:0] count [2];
		dtcm_pkg::result_t latched [2];
		logic [6:0] status [2];
		bit in_aging [2];
		logic [2:0] aging [2];
		bit saved_fail [2];
		status_beat_t pending_status [$];
		int errors;
		int checked;

		function new();
			fail_limit = dtcm_pkg::FAIL_LIMIT_RESET;
			threshold = dtcm_pkg::DEBOUNCE_THR_RESET;
			for (int i = 0; i < 2; i++) begin
				count[i] = '0;
				latched[i] = dtcm_pkg::RES_NONE;
				status[i] = '0;
				in_aging[i] = 0;
				aging[i] = '0;
				saved_fail[i] = 0;
			end
			errors = 0;
			checked = 0;
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		// Debounce, then status byte / confirm / aging update of the addressed record
		function void note_beat(bit ch, logic [15:0] v, bit p, bit n);
			int c;
			int t;
			bit fail, done, restart, stop_now, cond;
			bit b0, b1, b2, b3, b4, b5, b6;
			logic [6:0] st;
			status_beat_t e;
			t = threshold;
			c = count[ch];
			if (v < fail_limit)
				c = c - 1;
			else if (c >= 0)
				c = c + 2;
			else
				c = 1;
			if (c >= t) begin
				latched[ch] = dtcm_pkg::RES_FAIL;
				c = 0;
			end else if (c <= -t) begin
				latched[ch] = dtcm_pkg::RES_PASS;
				c = 0;
			end
			count[ch] = 9'(c);

			fail = (latched[ch] == dtcm_pkg::RES_FAIL);
			done = fail || (latched[ch] == dtcm_pkg::RES_PASS);
			restart = !p && n;
			stop_now = !n;
			st = status[ch];
			b1 = st[dtcm_pkg::SB_FAILED_CYCLE];
			b2 = st[dtcm_pkg::SB_PENDING];
			b3 = st[dtcm_pkg::SB_CONFIRMED];
			b4 = st[dtcm_pkg::SB_NOT_DONE_CLR];
			b5 = st[dtcm_pkg::SB_FAILED_CLR];
			b6 = st[dtcm_pkg::SB_NOT_DONE_CYCLE];

			b0 = fail;
			if (restart)
				b1 = 0;
			else if (fail)
				b1 = 1;
			if (fail)
				b2 = 1;
			else if (stop_now && !b1)
				b2 = 0;

			// confirm stage, then aging stage
			cond = b1 && saved_fail[ch];
			if (!in_aging[ch]) begin
				if (cond) begin
					b3 = 1;
					aging[ch] = '0;
					in_aging[ch] = 1;
				end else begin
					b3 = 0;
				end
			end else begin
				if (aging[ch] == dtcm_pkg::AGING_RELEASE) begin
					b3 = 0;
					in_aging[ch] = 0;
					aging[ch] = '0;
				end else if (fail) begin
					aging[ch] = '0;
				end else if (!cond && stop_now) begin
					aging[ch] = aging[ch] + 3'd1;
				end
			end

			if (done)
				b4 = 0;
			if (aging[ch] == dtcm_pkg::AGING_CLEAR_SINCE)
				b5 = 0;
			else if (fail)
				b5 = 1;
			if (restart)
				b6 = 1;
			else if (done)
				b6 = 0;

			st = '0;
			st[dtcm_pkg::SB_FAILED] = b0;
			st[dtcm_pkg::SB_FAILED_CYCLE] = b1;
			st[dtcm_pkg::SB_PENDING] = b2;
			st[dtcm_pkg::SB_CONFIRMED] = b3;
			st[dtcm_pkg::SB_NOT_DONE_CLR] = b4;
			st[dtcm_pkg::SB_FAILED_CLR] = b5;
			st[dtcm_pkg::SB_NOT_DONE_CYCLE] = b6;
			status[ch] = st;
			// stop-stop cycle: keep failed-this-cycle for the next confirmation
			if (!p && stop_now)
				saved_fail[ch] = b1;

			e.channel = ch;
			e.status = st;
			e.result = latched[ch];
			e.aging = aging[ch];
			pending_status.push_back(e);
		endfunction

		task check_beat(logic ch, logic [6:0] st, logic [1:0] res, logic [2:0] ag);
			status_beat_t e;
			checked++;
			if (pending_status.size() == 0) begin
				report($sformatf("unexpected result beat ch=%0d status=%h", ch, st));
			end else begin
				e = pending_status.pop_front();
				if (ch !== e.channel || st !== e.status || res !== e.result
						|| ag !== e.aging)
					report($sformatf(
						"ch %0d/%0d status %h/%h result %0d/%0d aging %0d/%0d (got/exp)",
						ch, e.channel, st, e.status, res, e.result, ag, e.aging));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic channel;
	logic [15:0] sensor_value;
	logic cycle_prev;
	logic cycle_now;
	logic out_valid;
	logic out_stall;
	logic channel_out;
	logic [6:0] status_byte;
	logic [1:0] test_result;
	logic [2:0] aging_count;

	dtc_scoreboard sb;
	int beats_sent;
	int hold_off_cycles;
	bit burst;
	logic [15:0] cur_limit;
	int fail_pct [2];
	bit running [2];

	dtc_status_monitor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel(channel),
		.sensor_value(sensor_value),
		.cycle_prev(cycle_prev),
		.cycle_now(cycle_now),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.channel_out(channel_out),
		.status_byte(status_byte),
		.test_result(test_result),
		.aging_count(aging_count)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Watchdog
	initial begin
		#800000;
		$display("simulation failed");
		$finish;
	end

	// Beat monitors on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_beat(channel, sensor_value, cycle_prev, cycle_now);
			if (out_valid && !out_stall)
				sb.check_beat(channel_out, status_byte, test_result, aging_count);
		end
	end

	// Result receiver: random stall before each beat, optional long hold-off
	initial begin
		int n;
		out_stall = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				n = burst ? 0 : $urandom_range(0, 13);
			end
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_beat(bit ch, logic [15:0] v, bit p, bit n);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		channel <= ch;
		sensor_value <= v;
		cycle_prev <= p;
		cycle_now <= n;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	// Mostly well-formed operation cycles per channel, some random flag noise
	task automatic rand_beat();
		bit ch, p, n;
		logic [15:0] v;
		ch = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 19) == 0)
			fail_pct[ch] = $urandom_range(0, 4) * 25;
		if ($urandom_range(0, 99) < 15) begin
			p = 1'($urandom_range(0, 1));
			n = 1'($urandom_range(0, 1));
		end else if (!running[ch]) begin
			p = 0;
			n = ($urandom_range(0, 3) == 0);
			running[ch] = n;
		end else begin
			p = 1;
			n = ($urandom_range(0, 4) != 0);
			running[ch] = n;
		end
		if ($urandom_range(0, 19) == 0)
			v = 16'($urandom());
		else if (cur_limit == 0 || $urandom_range(0, 99) < fail_pct[ch])
			v = 16'($urandom_range(65535, cur_limit));
		else
			v = 16'($urandom_range(cur_limit - 1, 0));
		send_beat(ch, v, p, n);
	endtask

	// Wait until every sent beat has reported, then let the pipeline settle
	task automatic drain();
		in_valid <= 0;
		while (sb.checked < beats_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [15:0] lim, logic [6:0] thr);
		cfg_we <= 1;
		cfg_index <= dtcm_pkg::CFG_FAIL_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_index <= dtcm_pkg::CFG_DEBOUNCE_THR;
		cfg_data <= {9'd0, thr};
		@(posedge clk);
		cfg_we <= 0;
		sb.fail_limit = lim;
		sb.threshold = thr;
		cur_limit = lim;
	endtask

	initial begin
		logic [15:0] lim;
		logic [6:0] thr;
		int cnt;
		sb = new();
		beats_sent = 0;
		hold_off_cycles = 0;
		burst = 0;
		cur_limit = dtcm_pkg::FAIL_LIMIT_RESET;
		fail_pct[0] = 50;
		fail_pct[1] = 50;
		running[0] = 0;
		running[1] = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = dtcm_pkg::CFG_FAIL_LIMIT;
		cfg_data = '0;
		in_valid = 0;
		channel = 0;
		sensor_value = '0;
		cycle_prev = 0;
		cycle_now = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset configuration
		repeat (200) rand_beat();
		drain();

		// directed: fail into confirmation, then passes while confirmed, limit boundary
		configure(16'd100, 7'd2);
		send_beat(0, 16'hFFFF, 0, 1);
		send_beat(0, 16'hFFFF, 1, 1);
		send_beat(0, 16'hFFFF, 1, 0);
		send_beat(0, 16'hFFFF, 0, 0);
		send_beat(0, 16'hFFFF, 0, 1);
		send_beat(0, 16'hFFFF, 1, 1);
		send_beat(0, 16'd0, 1, 0);
		repeat (8) send_beat(0, 16'd0, 0, 0);
		send_beat(1, 16'd99, 1, 1);
		send_beat(1, 16'd100, 1, 1);
		send_beat(1, 16'd0, 0, 0);
		send_beat(1, 16'd100, 0, 1);
		send_beat(1, 16'hFFFF, 1, 0);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			cnt = 150;
			burst = (ph == 3 || ph == 6);
			case (ph)
				0: begin lim = 16'd0; thr = 7'd1; end
				1: begin lim = 16'hFFFF; thr = 7'd127; end
				2: begin lim = 16'($urandom()); thr = 7'd0; cnt = 80; end
				3: begin
					lim = 16'($urandom_range(60000, 200));
					thr = 7'($urandom_range(6, 1));
				end
				4: begin lim = 16'h8000; thr = 7'd3; end
				5: begin lim = 16'($urandom()); thr = 7'($urandom_range(127, 1)); end
				6: begin lim = 16'd100; thr = 7'd5; end
				default: begin lim = 16'd1; thr = 7'd2; end
			endcase
			configure(lim, thr);
			// long receiver hold-off while the sender keeps offering
			if (ph == 3)
				hold_off_cycles = 80;
			repeat (cnt) rand_beat();
			drain();
		end

		burst = 0;
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_status.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
